>>> rtl/tds_median_temp_compensated_assert.svh
// Assertion macros for the TDS median block
`ifndef TDS_MEDIAN_TEMP_COMPENSATED_ASSERT_SVH
`define TDS_MEDIAN_TEMP_COMPENSATED_ASSERT_SVH
`ifndef SYNTHESIS
`define TDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TDS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TDS_ASSERT(lbl, clk, rstn, prop, msg)
`define TDS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/tds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the TDS measurement block.
// ----------------------------------------------------------------------------
package tds_pkg;
  // ADC resolution; full scale is 2^ADC_BITS codes
  localparam int ADC_BITS = 12;

  localparam logic [1:0] CMD_STORE      = 2'd0;
  localparam logic [1:0] CMD_STORE_MEAS = 2'd1;
  localparam logic [1:0] CMD_MEAS       = 2'd2;

  localparam logic [1:0] REG_VREF  = 2'd0;
  localparam logic [1:0] REG_REFT  = 2'd1;
  localparam logic [1:0] REG_SLOPE = 2'd2;

  localparam logic [17:0] COEF_MAX = 18'h3FFFF;
  localparam logic [19:0] VC_MAX   = 20'hFFFFF;
  localparam logic [19:0] TDS_MAX  = 20'hFFFFF;
  localparam logic [17:0] CURVE_A  = 18'd34156;
  localparam logic [16:0] CURVE_B  = 17'd65500;
  localparam logic [17:0] CURVE_C  = 18'd219492;

  // Shared-unit request from the sequencer
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;
endpackage
`default_nettype wire

>>> rtl/tds_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tds_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tds_pkg::div_req_t  req_i,
  output logic                    busy_o,
  output logic [63:0]             quo_o
);
  import tds_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [48:0] rem_q, rem_d;
  logic [47:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic [48:0] trial;

  assign trial = {rem_q[47:0], quo_q[63]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      quo_d = req_i.num;
      rem_d = '0;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) den_q <= req_i.den;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

>>> rtl/tds_median_temp_compensated.sv
`timescale 1ns / 1ps
`default_nettype none
// A measurement reaches out_valid_o after the rank-count median scan (for
// each candidate, the candidate and then every ring entry are read), the
// scaling steps and the divide. The next item is accepted only once the
// result has left S_WAIT with out_stall_i low. A store-only item keeps the
// block idle, ready for the next item. Reset clears the ring via valid
// bits, the write pointer and the configuration registers to 3300 mV, 400, 1311.
// ----------------------------------------------------------------------------
// tds_median_temp_compensated
// Sequencer: ring store, rank-count median, scaling, divide and cubic curve.
// ----------------------------------------------------------------------------
`include "tds_median_temp_compensated_assert.svh"
module tds_median_temp_compensated #(
  parameter int SAMPLES  = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [11:0] adc_sample_i,
  input  wire logic signed [11:0] water_temp_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      median_sample_o,
  output logic [22:0]      voltage_uv_o,
  output logic [19:0]      tds_x16_o,
  output logic             temp_clamped_o
);
  import tds_pkg::*;

  localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CW = $clog2(SAMPLES + 1);
  localparam logic [AW-1:0] LAST = AW'(SAMPLES - 1);
  localparam logic [CW-1:0] K_LO = CW'((SAMPLES - 1) / 2);
  localparam logic [CW-1:0] K_HI = CW'(SAMPLES / 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OUTER = 4'd1;
  localparam logic [3:0] S_INNER = 4'd2;
  localparam logic [3:0] S_JUDGE = 4'd3;
  localparam logic [3:0] S_VOLT  = 4'd4;
  localparam logic [3:0] S_COEF  = 4'd5;
  localparam logic [3:0] S_DEN   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_V2    = 4'd8;
  localparam logic [3:0] S_V3    = 4'd9;
  localparam logic [3:0] S_P1    = 4'd10;
  localparam logic [3:0] S_P2    = 4'd11;
  localparam logic [3:0] S_P3    = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_WAIT  = 4'd14;

  // Sample ring memory with per-entry valid bits
  logic [ADC_BITS-1:0] ring_mem [SAMPLES];
  logic [SAMPLES-1:0]  vld_q;
  logic [AW-1:0]       wpos_q;
  logic [ADC_BITS-1:0] rd_q;
  logic                rd_v_q;
  logic [ADC_BITS-1:0] rd_val;

  logic [12:0] vref_q;
  logic [10:0] reft_q;
  logic [15:0] slope_q;

  logic [3:0]  st_q;
  logic [AW-1:0] i_q, j_q, rdaddr;
  logic [ADC_BITS-1:0] cand_q;
  logic [CW-1:0] lt_q, le_q;
  logic        pend_q;
  logic [ADC_BITS-1:0] lo_q, hi_q;
  logic [11:0] med_q;
  logic        clamp_q;
  logic [10:0] t_q;
  logic [47:0] acc_q;
  logic [22:0] volt_q;
  logic [17:0] coef_q;
  logic [19:0] vc_q;
  logic [35:0] v2_q;
  logic [35:0] v3_q;
  logic [59:0] prod_q;
  logic signed [63:0] poly_q;
  div_req_t    dreq;
  logic        dbusy;
  logic [63:0] dquo;

  tds_div u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(dreq), .busy_o(dbusy), .quo_o(dquo)
  );

  assign cfg_ready_o = (st_q == S_IDLE);
  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = (st_q == S_WAIT);

  logic accept, meas;
  assign accept = in_valid_i && !in_stall_o;
  assign meas   = (cmd_i == CMD_STORE_MEAS) || (cmd_i == CMD_MEAS);

  logic lastj;
  assign lastj = (j_q == LAST);

  // Read address runs one ahead of j: candidate i, then entries 0..LAST
  assign rdaddr = (st_q == S_OUTER) ? i_q :
                  ((st_q == S_INNER) && !pend_q && !lastj) ? j_q + AW'(1) : '0;
  assign rd_val = rd_v_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (accept && ((cmd_i == CMD_STORE) || (cmd_i == CMD_STORE_MEAS)))
      ring_mem[wpos_q] <= adc_sample_i[ADC_BITS-1:0];
    rd_q <= ring_mem[rdaddr];
  end

  // Clamp temperature
  logic        tneg, tbig;
  assign tneg = water_temp_i[11];
  assign tbig = !tneg && (water_temp_i > 12'sd1600);

  logic signed [28:0] cnum;
  assign cnum = $signed({1'b0, 21'd1048576}) +
                $signed({1'b0, slope_q}) * ($signed({1'b0, t_q}) - $signed({1'b0, reft_q}));

  always_comb begin
    dreq       = '0;
    dreq.start = (st_q == S_DEN);
    dreq.num   = {9'd0, volt_q, 32'd0};
    dreq.den   = 48'(coef_q) * 48'd1000000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      vld_q   <= '0;
      wpos_q  <= '0;
      vref_q  <= 13'd3300;
      reft_q  <= 11'd400;
      slope_q <= 16'd1311;
      rd_v_q  <= 1'b0;
    end else begin
      rd_v_q <= vld_q[rdaddr];
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_VREF:  vref_q  <= cfg_data_i[12:0];
          REG_REFT:  reft_q  <= cfg_data_i[10:0];
          REG_SLOPE: slope_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        S_IDLE: begin
          if (accept) begin
            if ((cmd_i == CMD_STORE) || (cmd_i == CMD_STORE_MEAS)) begin
              vld_q[wpos_q] <= 1'b1;
              wpos_q <= (wpos_q == LAST) ? '0 : wpos_q + AW'(1);
            end
            if (meas) st_q <= S_OUTER;
          end
        end
        S_OUTER: st_q <= S_INNER;
        S_INNER: if (lastj && !pend_q) st_q <= S_JUDGE;
        S_JUDGE: st_q <= (i_q == LAST) ? S_VOLT : S_OUTER;
        S_VOLT:  st_q <= S_COEF;
        S_COEF:  st_q <= S_DEN;
        S_DEN:   st_q <= S_DIV;
        S_DIV:   if (!dbusy) st_q <= S_V2;
        S_V2:    st_q <= S_V3;
        S_V3:    st_q <= S_P1;
        S_P1:    st_q <= S_P2;
        S_P2:    st_q <= S_P3;
        S_P3:    st_q <= S_OUT;
        S_OUT:   st_q <= S_WAIT;
        S_WAIT:  if (!out_stall_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: rank-count median then fixed-point chain
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          clamp_q  <= tneg || tbig;
          t_q      <= tneg ? 11'd0 : (tbig ? 11'd1600 : water_temp_i[10:0]);
          i_q      <= '0;
          lo_q     <= '0;
          hi_q     <= '0;
        end
      end
      S_OUTER: begin
        // fetch candidate i first through the read port
        j_q    <= i_q;
        pend_q <= 1'b1;
        lt_q   <= '0;
        le_q   <= '0;
      end
      S_INNER: begin
        if (pend_q) begin
          pend_q <= 1'b0;
          cand_q <= rd_val;
          j_q    <= '0;
          // wait for first element read
        end else begin
          if (rd_val < cand_q) lt_q <= lt_q + CW'(1);
          if (rd_val <= cand_q) le_q <= le_q + CW'(1);
          if (!lastj) j_q <= j_q + AW'(1);
        end
      end
      S_JUDGE: begin
        if (lt_q <= K_LO && le_q > K_LO) lo_q <= cand_q;
        if (lt_q <= K_HI && le_q > K_HI) hi_q <= cand_q;
        i_q <= i_q + AW'(1);
      end
      S_VOLT: begin
        med_q  <= 12'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));
        acc_q  <= 48'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1) * 48'(vref_q) * 48'd1000;
      end
      S_COEF: begin
        volt_q <= 23'(acc_q >> ADC_BITS);
        if (cnum < 29'sd16) coef_q <= 18'd1;
        else if ((cnum >>> 4) > $signed({11'd0, COEF_MAX})) coef_q <= COEF_MAX;
        else coef_q <= 18'(cnum >>> 4);
      end
      S_DIV: if (!dbusy)
        vc_q <= (dquo > {44'd0, VC_MAX}) ? VC_MAX : dquo[19:0];
      S_V2: v2_q <= 36'((40'(vc_q) * 40'(vc_q)) >> 16);
      S_V3: v3_q <= 36'((56'(v2_q) * 56'(vc_q)) >> 16);
      S_P1: begin
        prod_q <= 60'(v3_q) * 60'(CURVE_A);
      end
      S_P2: begin
        poly_q <= $signed({4'd0, prod_q}) - $signed(64'(v2_q) * 64'(CURVE_B));
      end
      S_P3: poly_q <= poly_q + $signed(64'(vc_q) * 64'(CURVE_C));
      S_OUT: begin
        if (poly_q < 0) tds_x16_o <= '0;
        else if ((poly_q >>> 21) > $signed({44'd0, TDS_MAX})) tds_x16_o <= TDS_MAX;
        else tds_x16_o <= 20'(poly_q >>> 21);
        median_sample_o <= med_q;
        voltage_uv_o    <= volt_q;
        temp_clamped_o  <= clamp_q;
      end
      default: ;
    endcase
  end

  `TDS_ASSERT(a_busy_stall, clk_i, rst_ni, (st_q != S_IDLE) |-> in_stall_o, "busy not stalled")
  `TDS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o, "out dropped")
  `TDS_ASSERT(a_div_done, clk_i, rst_ni, (st_q == S_V2) |-> !dbusy, "div busy")
  `TDS_ASSERT(a_wpos, clk_i, rst_ni, wpos_q <= LAST, "write pointer range")
  `TDS_ASSERT_NEVER(a_state_range, clk_i, rst_ni, st_q > S_WAIT, "illegal state")
endmodule
`default_nettype wire
